// ===== rtl/assert_macros.svh =====
// Assertion helpers for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define SLPG_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("slpg assertion failed");

// Whenever the condition holds, the consequence must hold in the next cycle.
`define SLPG_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("slpg assertion failed");

`endif

// ===== rtl/slpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slpg_pkg;

  localparam int CosTableDepthDef = 256;

  // Field widths.
  localparam int ModeW   = 2;
  localparam int StatusW = 3;
  localparam int FlashW  = 32;
  localparam int LevelW  = 8;
  localparam int FactW   = 17;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK  = 2'd0,
    MODE_BASE  = 2'd1,
    MODE_FLASH = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OFF        = 3'd0,
    STAT_BOOT       = 3'd1,
    STAT_SETUP      = 3'd2,
    STAT_CONNECTING = 3'd3,
    STAT_CONNECTED  = 3'd4,
    STAT_BUSY       = 3'd5,
    STAT_LOCKOUT    = 3'd6,
    STAT_FAULT      = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PREP,
    FSM_DIV,
    FSM_MULK,
    FSM_MULG,
    FSM_SCALE
  } fsm_e;

  // Phase counter periods and on-times in milliseconds, and counter widths in bits.
  localparam int BreathePeriod = 3000;
  localparam int ConnectPeriod = 1200;
  localparam int BusyPeriod    = 240;
  localparam int BusyOn        = 120;
  localparam int FaultPeriod   = 1600;
  localparam int FaultOn       = 250;
  localparam int BreatheW      = 12;
  localparam int ConnectW      = 11;
  localparam int BusyW         = 8;
  localparam int FaultW        = 11;

  // Q1.16 pattern factors; 65536 is exactly one.
  localparam logic [FactW-1:0] KOne = 17'd65536;
  localparam logic [FactW-1:0] K035 = 17'd22938;
  localparam logic [FactW-1:0] K018 = 17'd11796;
  localparam logic [FactW-1:0] K080 = 17'd52429;
  localparam logic [FactW-1:0] K008 = 17'd5243;
  localparam logic [FactW-1:0] K092 = 17'd60293;
  localparam logic [FactW-1:0] K015 = 17'd9830;
  localparam logic [FactW-1:0] K085 = 17'd55706;
  localparam logic [FactW-1:0] K045 = 17'd29491;
  localparam logic [FactW-1:0] K075 = 17'd49152;

  // Q30 constants for building the raised cosine table.
  localparam longint unsigned OneQ30 = 64'd1073741824;
  localparam longint unsigned PiQ30  = 64'd3373259426;

  localparam logic [LevelW-1:0] PeakReset = 8'd64;

endpackage

`default_nettype wire

// ===== rtl/slpg_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface slpg_item_if;
  logic                              valid;
  logic                              ready;
  logic [slpg_pkg::ModeW-1:0]        mode;
  logic [slpg_pkg::StatusW-1:0]      status_code;
  logic [slpg_pkg::FlashW-1:0]       flash_ms;

  modport source (output valid, mode, status_code, flash_ms, input ready);
  modport sink   (input valid, mode, status_code, flash_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/slpg_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface slpg_result_if;
  logic                              valid;
  logic                              ready;
  logic [slpg_pkg::LevelW-1:0]       red;
  logic [slpg_pkg::LevelW-1:0]       green;
  logic [slpg_pkg::LevelW-1:0]       blue;
  logic [slpg_pkg::StatusW-1:0]      shown_status;

  modport source (output valid, red, green, blue, shown_status, input ready);
  modport sink   (input valid, red, green, blue, shown_status, output ready);
endinterface

`default_nettype wire

// ===== rtl/slpg_serial_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider that produces one quotient bit per cycle, MSB first.
// The caller preloads the partial remainder, which must be below the divisor.
module slpg_serial_div #(
  parameter int QW   = 8,
  parameter int RemW = 13,
  parameter int DivW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RemW-1:0] rem_i,
  input  logic [QW-1:0]   bits_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [QW-1:0]   quot_o
);

  localparam int CntW = $clog2(QW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [RemW-1:0] rem_q;
  logic [QW-1:0]   bits_q;
  logic [QW-1:0]   quot_q;
  logic [DivW-1:0] div_q;

  logic [RemW-1:0] trial;
  logic            fits;
  logic [RemW-1:0] rem_d;

  always_comb begin
    trial = {rem_q[RemW-2:0], bits_q[QW-1]};
    fits  = trial >= RemW'(div_q);
    rem_d = fits ? trial - RemW'(div_q) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      bits_q <= bits_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      bits_q <= {bits_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/status_led_pattern_generator.sv =====
// Status LED pattern generator: one RGB transaction per millisecond tick.
// Commands are taken in idle and produce no result. A static pattern tick
// goes from idle to the scaling step, which loads the output register.
// A breathing tick first runs the prepare, bit-serial table index division,
// factor multiply and green multiply steps before the scaling step.
// A held result adds its wait. Async active-low reset: boot, no flash, peak 64.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module status_led_pattern_generator #(
  parameter int COSINE_TABLE_DEPTH = slpg_pkg::CosTableDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  slpg_item_if.sink                   item_i,
  slpg_result_if.source               result_o,
  input  logic                        cfg_we_i,
  input  logic [slpg_pkg::LevelW-1:0] cfg_wdata_i
);

  // The cosine table index is floor(phase * DEPTH / period). Since phase is
  // below period, the index fits in QW bits and the top bits of the product
  // already form a partial remainder below the period, so only QW divider
  // steps are needed.
  localparam int QW     = $clog2(COSINE_TABLE_DEPTH);
  localparam int PhaseW = slpg_pkg::BreatheW;
  localparam int RemW   = PhaseW + 1;
  localparam int NumW   = PhaseW + QW;
  localparam int FactW  = slpg_pkg::FactW;
  localparam int ProdW  = 2 * FactW;
  localparam logic [NumW-1:0] DepthN = NumW'(COSINE_TABLE_DEPTH);

  typedef logic [FactW-1:0] rom_t [COSINE_TABLE_DEPTH];

  // Raised cosine table, sin^2(pi*i/D) in Q16, evaluated at elaboration with
  // a Q30 Taylor polynomial of sine on the folded angle.
  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned d;
    longint unsigned y;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned a;
    longint unsigned s;
    longint unsigned sq;
    d = longint'(COSINE_TABLE_DEPTH);
    for (int i = 0; i < COSINE_TABLE_DEPTH; i++) begin
      y  = (longint'(i) <= d - longint'(i)) ? longint'(i) : d - longint'(i);
      z  = (slpg_pkg::PiQ30 * y) / COSINE_TABLE_DEPTH;
      z2 = (z * z) >> 30;
      a  = slpg_pkg::OneQ30 - z2 / 72;
      a  = slpg_pkg::OneQ30 - ((z2 * a) >> 30) / 42;
      a  = slpg_pkg::OneQ30 - ((z2 * a) >> 30) / 20;
      a  = slpg_pkg::OneQ30 - ((z2 * a) >> 30) / 6;
      s  = (z * a) >> 30;
      sq = (s * s + (64'd1 << 43)) >> 44;
      if (sq > 64'd65536) begin
        sq = 64'd65536;
      end
      r[i] = FactW'(sq);
    end
    return r;
  endfunction

  localparam rom_t RcRom = build_rom();

  // Level = (peak * factor) >> 16, clamped to full scale.
  function automatic logic [slpg_pkg::LevelW-1:0] scale_lvl(
    input logic [slpg_pkg::LevelW-1:0] pk,
    input logic [FactW-1:0]            f
  );
    logic [slpg_pkg::LevelW+FactW-1:0] p;
    p = (slpg_pkg::LevelW+FactW)'(pk) * (slpg_pkg::LevelW+FactW)'(f);
    if (p[slpg_pkg::LevelW+FactW-1:16] > (slpg_pkg::LevelW+FactW-16)'(255)) begin
      return 8'd255;
    end
    return p[slpg_pkg::LevelW+15:16];
  endfunction

  // Control and pattern state.
  slpg_pkg::fsm_e                     state_q, state_d;
  logic [slpg_pkg::LevelW-1:0]        peak_q;
  slpg_pkg::status_e                  base_q;
  slpg_pkg::status_e                  flash_st_q;
  logic [slpg_pkg::FlashW-1:0]        flash_left_q;
  logic [slpg_pkg::BreatheW-1:0]      breathe_q;
  logic [slpg_pkg::ConnectW-1:0]      connect_q;
  logic [slpg_pkg::BusyW-1:0]         busy_q;
  logic [slpg_pkg::FaultW-1:0]        fault_q;
  logic                               out_valid_q;

  // Per-tick working registers.
  slpg_pkg::status_e                  st_q;
  logic [PhaseW-1:0]                  phase_q;
  logic [FactW-1:0]                   f1_q;
  logic [FactW-1:0]                   f2_q;
  logic [FactW-1:0]                   rom_q;
  logic [slpg_pkg::LevelW-1:0]        red_q, green_q, blue_q;
  slpg_pkg::status_e                  shown_q;

  logic                               item_ready;
  logic                               item_acc;
  logic                               tick_acc;
  logic                               div_start;
  logic                               div_done;
  logic [QW-1:0]                      div_quot;
  logic                               out_load;
  slpg_pkg::status_e                  cur_st;
  logic                               breathing;
  logic [FactW-1:0]                   fs1, fs2;
  logic [NumW-1:0]                    num;
  logic [PhaseW-1:0]                  period_sel;
  logic [FactW-1:0]                   kbase, kmul, kgreen;
  logic [ProdW-1:0]                   prod_k;
  logic [ProdW-1:0]                   prod_g;
  logic [slpg_pkg::LevelW-1:0]        lvl1, lvl2;
  logic [slpg_pkg::LevelW-1:0]        red_d, green_d, blue_d;

  // The flash status wins while flash time is left.
  assign cur_st    = (flash_left_q != '0) ? flash_st_q : base_q;
  assign breathing = (cur_st == slpg_pkg::STAT_SETUP) ||
                     (cur_st == slpg_pkg::STAT_CONNECTING);
  assign item_acc  = item_ready && item_i.valid;
  assign tick_acc  = item_acc && (item_i.mode == slpg_pkg::MODE_TICK);

  // Factors of the static patterns, taken from the phases before they advance.
  // Breathing patterns leave them at zero here and compute them later.
  always_comb begin
    fs1 = '0;
    fs2 = '0;
    unique case (cur_st)
      slpg_pkg::STAT_BOOT:      fs1 = slpg_pkg::K035;
      slpg_pkg::STAT_CONNECTED: fs1 = slpg_pkg::K018;
      slpg_pkg::STAT_BUSY: begin
        if (busy_q < slpg_pkg::BusyW'(slpg_pkg::BusyOn)) begin
          fs1 = slpg_pkg::KOne;
          fs2 = slpg_pkg::K035;
        end
      end
      slpg_pkg::STAT_LOCKOUT:   fs1 = slpg_pkg::KOne;
      slpg_pkg::STAT_FAULT: begin
        if (fault_q < slpg_pkg::FaultW'(slpg_pkg::FaultOn)) begin
          fs1 = slpg_pkg::K080;
        end
      end
      default: begin
        fs1 = '0;
        fs2 = '0;
      end
    endcase
  end

  // Sequencer: commands keep it in idle; ticks either go straight to
  // the scaling step or run the table lookup first.
  always_comb begin
    state_d    = state_q;
    item_ready = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      slpg_pkg::FSM_IDLE: begin
        item_ready = 1'b1;
        if (item_i.valid && (item_i.mode == slpg_pkg::MODE_TICK)) begin
          state_d = breathing ? slpg_pkg::FSM_PREP : slpg_pkg::FSM_SCALE;
        end
      end
      slpg_pkg::FSM_PREP: begin
        div_start = 1'b1;
        state_d   = slpg_pkg::FSM_DIV;
      end
      slpg_pkg::FSM_DIV: begin
        if (div_done) begin
          state_d = slpg_pkg::FSM_MULK;
        end
      end
      slpg_pkg::FSM_MULK: state_d = slpg_pkg::FSM_MULG;
      slpg_pkg::FSM_MULG: state_d = slpg_pkg::FSM_SCALE;
      slpg_pkg::FSM_SCALE: begin
        // The output register frees up when its transaction completes.
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = slpg_pkg::FSM_IDLE;
        end
      end
      default: state_d = slpg_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slpg_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pattern state: peak register, base and flash status, flash countdown and the
  // four phase counters, which advance only on accepted ticks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q       <= slpg_pkg::PeakReset;
      base_q       <= slpg_pkg::STAT_BOOT;
      flash_st_q   <= slpg_pkg::STAT_OFF;
      flash_left_q <= '0;
      breathe_q    <= '0;
      connect_q    <= '0;
      busy_q       <= '0;
      fault_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        peak_q <= cfg_wdata_i;
      end
      if (item_acc) begin
        unique case (slpg_pkg::mode_e'(item_i.mode))
          slpg_pkg::MODE_BASE: begin
            base_q <= slpg_pkg::status_e'(item_i.status_code);
          end
          slpg_pkg::MODE_FLASH: begin
            flash_st_q   <= slpg_pkg::status_e'(item_i.status_code);
            flash_left_q <= item_i.flash_ms;
          end
          slpg_pkg::MODE_TICK: begin
            breathe_q <= (breathe_q == slpg_pkg::BreatheW'(slpg_pkg::BreathePeriod - 1)) ?
                         '0 : breathe_q + 1'b1;
            connect_q <= (connect_q == slpg_pkg::ConnectW'(slpg_pkg::ConnectPeriod - 1)) ?
                         '0 : connect_q + 1'b1;
            busy_q    <= (busy_q == slpg_pkg::BusyW'(slpg_pkg::BusyPeriod - 1)) ?
                         '0 : busy_q + 1'b1;
            fault_q   <= (fault_q == slpg_pkg::FaultW'(slpg_pkg::FaultPeriod - 1)) ?
                         '0 : fault_q + 1'b1;
            if (flash_left_q != '0) begin
              flash_left_q <= flash_left_q - 1'b1;
            end
          end
          default: begin
            // Unused mode code: the transaction is dropped.
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table index: phase * DEPTH divided serially by the breathing period.
  assign num        = NumW'(phase_q) * DepthN;
  assign period_sel = (st_q == slpg_pkg::STAT_SETUP) ?
                      PhaseW'(slpg_pkg::BreathePeriod) : PhaseW'(slpg_pkg::ConnectPeriod);

  slpg_serial_div #(
    .QW   (QW),
    .RemW (RemW),
    .DivW (PhaseW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_i     (RemW'(num[NumW-1:QW])),
    .bits_i    (num[QW-1:0]),
    .divisor_i (period_sel),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Breathing factor: k = base + (span * rc) >> 16, and the green share
  // (k * ratio) >> 16.
  always_comb begin
    if (st_q == slpg_pkg::STAT_SETUP) begin
      kbase  = slpg_pkg::K008;
      kmul   = slpg_pkg::K092;
      kgreen = slpg_pkg::K075;
    end else begin
      kbase  = slpg_pkg::K015;
      kmul   = slpg_pkg::K085;
      kgreen = slpg_pkg::K045;
    end
    prod_k = ProdW'(kmul) * ProdW'(rom_q);
    prod_g = ProdW'(f1_q) * ProdW'(kgreen);
  end

  // Channel mapping of the two scaled levels for each status.
  always_comb begin
    lvl1    = scale_lvl(peak_q, f1_q);
    lvl2    = scale_lvl(peak_q, f2_q);
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    unique case (st_q)
      slpg_pkg::STAT_OFF: begin
      end
      slpg_pkg::STAT_BOOT: begin
        red_d   = lvl1;
        green_d = lvl1;
        blue_d  = lvl1;
      end
      slpg_pkg::STAT_SETUP: begin
        blue_d  = lvl1;
        green_d = lvl2;
      end
      slpg_pkg::STAT_CONNECTING: begin
        red_d   = lvl1;
        green_d = lvl2;
      end
      slpg_pkg::STAT_CONNECTED: green_d = lvl1;
      slpg_pkg::STAT_BUSY: begin
        green_d = lvl1;
        blue_d  = lvl2;
      end
      slpg_pkg::STAT_LOCKOUT: red_d = lvl1;
      slpg_pkg::STAT_FAULT:   red_d = lvl1;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      st_q    <= cur_st;
      phase_q <= (cur_st == slpg_pkg::STAT_SETUP) ? breathe_q : PhaseW'(connect_q);
      f1_q    <= fs1;
      f2_q    <= fs2;
    end
    if ((state_q == slpg_pkg::FSM_DIV) && div_done) begin
      rom_q <= RcRom[div_quot];
    end
    if (state_q == slpg_pkg::FSM_MULK) begin
      f1_q <= kbase + FactW'(prod_k >> 16);
    end
    if (state_q == slpg_pkg::FSM_MULG) begin
      f2_q <= FactW'(prod_g >> 16);
    end
    if (out_load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      shown_q <= st_q;
    end
  end

  assign item_i.ready          = item_ready;
  assign result_o.valid        = out_valid_q;
  assign result_o.red          = red_q;
  assign result_o.green        = green_q;
  assign result_o.blue         = blue_q;
  assign result_o.shown_status = shown_q;

  // Terms for the checks below.
  logic                        flash_tick;
  logic [slpg_pkg::FlashW-1:0] flash_left_dec;
  logic                        phases_ok;

  assign flash_tick     = tick_acc && (flash_left_q != '0);
  assign flash_left_dec = flash_left_q - 1'b1;
  assign phases_ok      = (breathe_q < slpg_pkg::BreatheW'(slpg_pkg::BreathePeriod)) &&
                          (connect_q < slpg_pkg::ConnectW'(slpg_pkg::ConnectPeriod)) &&
                          (busy_q < slpg_pkg::BusyW'(slpg_pkg::BusyPeriod)) &&
                          (fault_q < slpg_pkg::FaultW'(slpg_pkg::FaultPeriod));

  // A tick during a flash consumes exactly one millisecond of it.
  `SLPG_ASSERT_NEXT(a_flash_dec, clk_i, rst_ni, flash_tick, flash_left_q == $past(flash_left_dec))
  // Phase counters never leave their periods.
  `SLPG_ASSERT_SAME(a_phase_range, clk_i, rst_ni, 1'b1, phases_ok)
  // The divider only reports completion while the sequencer waits for it.
  `SLPG_ASSERT_SAME(a_div_done_state, clk_i, rst_ni, div_done, state_q == slpg_pkg::FSM_DIV)

endmodule

`default_nettype wire
